@@ sv/spd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_pkg
// Shared constants, codes and types of the sensor packet deframer.
// ----------------------------------------------------------------------------
package spd_pkg;

    localparam int DEF_FRAME_CAPACITY = 64;   // default frame buffer depth
    localparam int HDR_LEN            = 6;    // header bytes
    localparam int LEN_END            = 8;    // first byte after the length field
    localparam int FRAME_OVERHEAD     = 9;    // header + length + checksum, less one

    // Result status codes
    localparam logic [1:0] ST_GOOD  = 2'd0;
    localparam logic [1:0] ST_CKSUM = 2'd1;
    localparam logic [1:0] ST_LEN   = 2'd2;

    // Command handed from the front end to the play-out engine
    typedef struct packed {
        logic       is_play;   // 1: play out a bank, 0: single error result
        logic       bank;      // bank holding the frame
        logic [1:0] status;    // error status when not a play command
        logic [6:0] length;    // frame length reported in the results
    } t_cmd;

    // Frame buffer write port
    typedef struct packed {
        logic       en;
        logic       bank;
        logic [5:0] pos;
        logic [7:0] data;
    } t_wr;

    // Play-out engine status
    typedef struct packed {
        logic act;    // a bank is being played out
        logic bank;   // bank being played out
        logic rel;    // last byte of the bank read, bank is free again
    } t_bst;

endpackage
`default_nettype wire

@@ sv/spd_cmd_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_cmd_fifo
// Two-entry command queue between the front end and the play-out engine.
// ----------------------------------------------------------------------------
module spd_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire spd_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_vld,
    output spd_pkg::t_cmd      o_cmd
);

    spd_pkg::t_cmd r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_vld   = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

@@ sv/spd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_front
// Byte receiver: header match, length and checksum tracking, buffer writes.
// ----------------------------------------------------------------------------
module spd_front #(
    parameter int FRAME_CAPACITY = spd_pkg::DEF_FRAME_CAPACITY
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [47:0]   i_cfg_wdata,
    input  wire logic          i_push,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_full,
    input  wire logic          i_q_full,
    output logic               o_q_push,
    output spd_pkg::t_cmd      o_q_cmd,
    output spd_pkg::t_wr       o_wr,
    input  wire spd_pkg::t_bst i_bst
);

    localparam logic [7:0] MAX_LEN = 8'(FRAME_CAPACITY - spd_pkg::FRAME_OVERHEAD);
    localparam logic [6:0] CAP     = 7'(FRAME_CAPACITY);

    logic [47:0] r_hdr;
    logic [6:0]  r_cnt;
    logic [6:0]  r_tot;
    logic [15:0] r_sum;
    logic [7:0]  r_len_hi;
    logic [7:0]  r_ck_hi;
    logic        r_wbank;
    logic [1:0]  r_busy;

    logic        acc;
    logic [7:0]  want;
    logic [15:0] sum_add;
    logic        len_bad;
    logic        done;
    logic        ck_ok;

    assign o_full  = r_busy[r_wbank] || i_q_full;
    assign acc     = i_push && !o_full;
    assign sum_add = r_sum + {8'd0, i_rx_byte};
    assign len_bad = (r_len_hi != 8'd0) ? 1'b1
                   : ((i_rx_byte < 8'd2) || (i_rx_byte > MAX_LEN));
    assign done    = (r_cnt >= 7'(spd_pkg::LEN_END)) && (r_cnt + 7'd1 == r_tot);
    assign ck_ok   = ({r_ck_hi, i_rx_byte} == r_sum);

    always_comb begin
        unique case (r_cnt[2:0])
            3'd0:    want = r_hdr[47:40];
            3'd1:    want = r_hdr[39:32];
            3'd2:    want = r_hdr[31:24];
            3'd3:    want = r_hdr[23:16];
            3'd4:    want = r_hdr[15:8];
            3'd5:    want = r_hdr[7:0];
            default: want = 8'd0;
        endcase
    end

    assign o_wr.en   = acc && (r_cnt < CAP);
    assign o_wr.bank = r_wbank;
    assign o_wr.pos  = r_cnt[5:0];
    assign o_wr.data = i_rx_byte;

    always_comb begin
        o_q_push        = 1'b0;
        o_q_cmd.is_play = 1'b0;
        o_q_cmd.bank    = r_wbank;
        o_q_cmd.status  = spd_pkg::ST_GOOD;
        o_q_cmd.length  = r_tot;
        if (acc && (r_cnt == 7'(spd_pkg::LEN_END - 1)) && len_bad) begin
            o_q_push       = 1'b1;
            o_q_cmd.status = spd_pkg::ST_LEN;
            o_q_cmd.length = 7'(spd_pkg::LEN_END);
        end else if (acc && done) begin
            o_q_push        = 1'b1;
            o_q_cmd.is_play = ck_ok;
            o_q_cmd.status  = ck_ok ? spd_pkg::ST_GOOD : spd_pkg::ST_CKSUM;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr   <= 48'd0;
            r_cnt   <= 7'd0;
            r_tot   <= 7'd0;
            r_sum   <= 16'd0;
            r_wbank <= 1'b0;
            r_busy  <= 2'b00;
        end else begin
            if (i_cfg_we) begin
                r_hdr <= i_cfg_wdata;
            end
            if (i_bst.rel) begin
                r_busy[i_bst.bank] <= 1'b0;
            end
            if (acc) begin
                priority if (r_cnt >= CAP) begin
                    r_cnt <= 7'd0;
                    r_tot <= 7'd0;
                    r_sum <= 16'd0;
                end else if (r_cnt < 7'(spd_pkg::HDR_LEN)) begin
                    // mismatching byte is dropped, not retried as a header start
                    r_cnt <= (i_rx_byte == want) ? r_cnt + 7'd1 : 7'd0;
                    r_tot <= 7'd0;
                    r_sum <= 16'd0;
                end else if (r_cnt < 7'(spd_pkg::LEN_END)) begin
                    if ((r_cnt == 7'(spd_pkg::LEN_END - 1)) && len_bad) begin
                        r_cnt <= 7'd0;
                        r_tot <= 7'd0;
                        r_sum <= 16'd0;
                    end else begin
                        r_cnt <= r_cnt + 7'd1;
                        r_sum <= sum_add;
                        if (r_cnt == 7'(spd_pkg::LEN_END - 1)) begin
                            r_tot <= 7'(spd_pkg::FRAME_OVERHEAD) + i_rx_byte[6:0];
                        end
                    end
                end else if (done) begin
                    r_cnt <= 7'd0;
                    r_tot <= 7'd0;
                    r_sum <= 16'd0;
                    if (ck_ok) begin
                        r_busy[r_wbank] <= 1'b1;
                        r_wbank         <= !r_wbank;
                    end
                end else begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt + 7'd3 <= r_tot) begin
                        r_sum <= sum_add;
                    end
                end
            end
        end
    end

    // length and checksum high bytes
    always_ff @(posedge i_clk) begin
        if (acc && (r_cnt == 7'(spd_pkg::HDR_LEN))) begin
            r_len_hi <= i_rx_byte;
        end
        if (acc && (r_cnt + 7'd2 == r_tot)) begin
            r_ck_hi <= i_rx_byte;
        end
    end

endmodule
`default_nettype wire

@@ sv/spd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spd_back
// Play-out engine: two-bank frame buffer and the result output register.
// ----------------------------------------------------------------------------
module spd_back #(
    parameter int FRAME_CAPACITY = spd_pkg::DEF_FRAME_CAPACITY
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire spd_pkg::t_wr  i_wr,
    input  wire logic          i_q_vld,
    input  wire spd_pkg::t_cmd i_q_cmd,
    output logic               o_q_pop,
    output spd_pkg::t_bst      o_bst,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic [7:0]         o_out_byte,
    output logic [5:0]         o_byte_index,
    output logic [6:0]         o_frame_length,
    output logic [1:0]         o_status,
    output logic               o_last_of_run
);

    localparam int AW = $clog2(FRAME_CAPACITY);

    logic [7:0] r_mem [2 << AW];
    logic [7:0] r_rd_data;

    logic       r_act;
    logic       r_bank;
    logic [5:0] r_k;
    logic [6:0] r_tot;

    logic       r_ovld;
    logic [5:0] r_oidx;
    logic [6:0] r_olen;
    logic [1:0] r_ostat;
    logic       r_olast;

    logic load;
    logic take_cmd;
    logic iss_rd;
    logic iss_err;
    logic rd_last;

    assign load     = !r_ovld || i_pop;
    assign take_cmd = !r_act && i_q_vld && load;
    assign iss_rd   = r_act && load;
    assign iss_err  = take_cmd && !i_q_cmd.is_play;
    assign rd_last  = iss_rd && ({1'b0, r_k} + 7'd1 == r_tot);
    assign o_q_pop  = take_cmd;

    assign o_bst.act  = r_act;
    assign o_bst.bank = r_bank;
    assign o_bst.rel  = rd_last;

    assign o_empty        = !r_ovld;
    assign o_out_byte     = (r_ostat == spd_pkg::ST_GOOD) ? r_rd_data : 8'd0;
    assign o_byte_index   = r_oidx;
    assign o_frame_length = r_olen;
    assign o_status       = r_ostat;
    assign o_last_of_run  = r_olast;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[{i_wr.bank, i_wr.pos[AW-1:0]}] <= i_wr.data;
        end
        if (iss_rd) begin
            r_rd_data <= r_mem[{r_bank, r_k[AW-1:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (load) begin
                r_ovld <= iss_rd || iss_err;
            end
            if (take_cmd && i_q_cmd.is_play) begin
                r_act <= 1'b1;
            end else if (rd_last) begin
                r_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_cmd && i_q_cmd.is_play) begin
            r_bank <= i_q_cmd.bank;
            r_tot  <= i_q_cmd.length;
            r_k    <= 6'd0;
        end else if (iss_rd) begin
            r_k <= r_k + 6'd1;
        end
        if (iss_rd) begin
            r_oidx  <= r_k;
            r_olen  <= r_tot;
            r_ostat <= spd_pkg::ST_GOOD;
            r_olast <= rd_last;
        end else if (iss_err) begin
            r_oidx  <= 6'd0;
            r_olen  <= i_q_cmd.length;
            r_ostat <= i_q_cmd.status;
            r_olast <= 1'b1;
        end
    end

endmodule
`default_nettype wire

@@ sv/sensor_packet_deframer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_packet_deframer
// Header, length and checksum packet deframer for a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_rx_byte and raise push; an item is taken at a
//   clock edge with push high and full low. One byte per cycle is taken
//   while full stays low. full rises when the frame buffer bank to be
//   filled next holds a frame not yet fully played out, or the command queue is full.
//   Result channel: while empty is low the oldest result sits on the o_*
//   ports; pop takes it. A good frame plays out one result per byte, one
//   per cycle when pop stays high; an error gives a single result.
//   Path: an error result passes the command queue and the output register;
//   a good frame starts play-out from the queue, then each byte is read out.
//   A frame buffer read port on the play-out side sets the one-per-cycle
//   output rate; the two banks let the next frame fill during play-out.
//   Receiver stall: results hold; the front end keeps taking bytes into the
//   other bank until that bank completes too, then full holds off the link.
//   Reset (i_rst_n low, synchronous): header register, counters, queue and
//   output register clear; buffer contents are left as they are.
//   Configuration: i_cfg_we writes the 48-bit header (first byte in the top
//   bits) at a clock edge; write it only while the block is idle.
// ----------------------------------------------------------------------------
module sensor_packet_deframer #(
    parameter int FRAME_CAPACITY = spd_pkg::DEF_FRAME_CAPACITY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [47:0] i_cfg_wdata,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_out_byte,
    output logic [5:0]       o_byte_index,
    output logic [6:0]       o_frame_length,
    output logic [1:0]       o_status,
    output logic             o_last_of_run
);

    // front end -> queue
    logic          q_push;
    spd_pkg::t_cmd q_in;
    logic          q_full;
    // queue -> play-out engine
    logic          q_vld;
    spd_pkg::t_cmd q_out;
    logic          q_pop;
    // buffer writes and engine status
    spd_pkg::t_wr  wr;
    spd_pkg::t_bst bst;

    spd_front #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_rx_byte   (i_rx_byte),
        .o_full      (full),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in),
        .o_wr        (wr),
        .i_bst       (bst)
    );

    // short queue so frame classification and play-out stall independently
    spd_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_cmd   (q_out)
    );

    spd_back #(
        .FRAME_CAPACITY (FRAME_CAPACITY)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_wr           (wr),
        .i_q_vld        (q_vld),
        .i_q_cmd        (q_out),
        .o_q_pop        (q_pop),
        .o_bst          (bst),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_out_byte     (o_out_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_length (o_frame_length),
        .o_status       (o_status),
        .o_last_of_run  (o_last_of_run)
    );

    // never overwrite the bank under play-out
    a_no_wr_active_bank : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr.en && bst.act) |-> (wr.bank != bst.bank))
        else $error("frame buffer write hit the bank being played out");

    // front end only issues commands when the queue has room
    a_no_push_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    // bank release only from an active play-out, which then ends
    a_rel_ends_play : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bst.rel |-> (bst.act ##1 !bst.act))
        else $error("bank release outside an active play-out");

    // an error result is always a single, final result
    a_err_is_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status != spd_pkg::ST_GOOD)) |-> (o_last_of_run && (o_out_byte == 8'd0)))
        else $error("error result without last mark or with data");

endmodule
`default_nettype wire

@@ sim/sensor_packet_deframer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_packet_deframer_tb
// Self-checking bench: feeds byte streams (directed frames, then random
// frames of every kind under several header settings and idle patterns)
// and checks each popped item against an in-bench deframer prediction.
// ----------------------------------------------------------------------------
module sensor_packet_deframer_tb;

    localparam int FRAME_CAP   = spd_pkg::DEF_FRAME_CAPACITY;
    localparam int RUN_LIMIT   = 200000;   // cycles, far above a slow run
    localparam int SETTLE_WAIT = 10;       // cycles after the last item drains
    localparam int PHASE_ITEMS = 10;       // minimum framed bytes per random phase

    typedef struct packed {
        logic [7:0] data;
        logic [5:0] idx;
        logic [6:0] len;
        logic [1:0] st;
        logic       last;
    } t_frame_result;

    typedef struct packed {
        logic [7:0]    rx;
        logic          typed;   // res below is the expected item
        t_frame_result res;
    } t_directed_row;

    typedef enum int {
        FR_NOISE,
        FR_BAD_HEADER,
        FR_BAD_LENGTH,
        FR_BAD_CKSUM,
        FR_GOOD,
        FR_GOOD_MAX
    } t_frame_kind;

    localparam t_frame_result NO_RES = '0;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [47:0] i_cfg_wdata = '0;
    logic        push        = 1'b0;
    logic [7:0]  i_rx_byte   = '0;
    logic        pop         = 1'b0;
    logic        full;
    logic        empty;
    logic [7:0]  o_out_byte;
    logic [5:0]  o_byte_index;
    logic [6:0]  o_frame_length;
    logic [1:0]  o_status;
    logic        o_last_of_run;

    sensor_packet_deframer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_rx_byte      (i_rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_out_byte     (o_out_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_length (o_frame_length),
        .o_status       (o_status),
        .o_last_of_run  (o_last_of_run)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Deframer shadow state
    // ------------------------------------------------------------------
    logic [7:0]  shadow_buf [0:FRAME_CAP-1];
    logic [6:0]  shadow_count  = '0;
    logic [6:0]  shadow_total  = '0;
    logic [15:0] shadow_sum    = '0;
    logic [47:0] shadow_header = '0;

    t_frame_result frame_results_due [$];

    int mismatches      = 0;
    int sender_idle_pct = 0;
    int recv_idle_pct   = 0;

    function automatic void drop_shadow_frame();
        shadow_count = '0;
        shadow_total = '0;
        shadow_sum   = '0;
    endfunction

    function automatic logic [7:0] header_byte(input int k);
        return shadow_header[8*(spd_pkg::HDR_LEN-1-k) +: 8];
    endfunction

    // One received byte through the deframer; queues the items it causes.
    task automatic deframe_byte(input logic [7:0] b);
        int unsigned   p;
        logic [15:0]   len16;
        logic [15:0]   ck;
        t_frame_result r;
        p = shadow_count;
        if (p >= FRAME_CAP) begin
            drop_shadow_frame();
            return;
        end
        // header: a wrong byte restarts the count and is not retried
        if (p < spd_pkg::HDR_LEN) begin
            if (b != header_byte(p)) begin
                drop_shadow_frame();
            end else begin
                shadow_buf[p] = b;
                shadow_count  = 7'(p + 1);
            end
            return;
        end
        shadow_buf[p] = b;
        shadow_count  = 7'(p + 1);
        if (p < spd_pkg::LEN_END) begin
            shadow_sum = shadow_sum + 16'(b);
            if (p == spd_pkg::LEN_END - 1) begin
                len16 = {shadow_buf[spd_pkg::HDR_LEN], shadow_buf[spd_pkg::HDR_LEN+1]};
                if (len16 < 2 || len16 > FRAME_CAP - spd_pkg::FRAME_OVERHEAD) begin
                    r = '{8'h00, 6'd0, 7'(spd_pkg::LEN_END), spd_pkg::ST_LEN, 1'b1};
                    frame_results_due.push_back(r);
                    drop_shadow_frame();
                end else begin
                    shadow_total = 7'(spd_pkg::FRAME_OVERHEAD + len16);
                end
            end
            return;
        end
        if (shadow_total < spd_pkg::FRAME_OVERHEAD + 2 || shadow_total > FRAME_CAP) begin
            drop_shadow_frame();
            return;
        end
        // the two checksum bytes stay out of the sum
        if (p + 3 <= shadow_total) shadow_sum = shadow_sum + 16'(b);
        if (shadow_count < shadow_total) return;
        ck = {shadow_buf[shadow_total-2], shadow_buf[shadow_total-1]};
        if (ck != shadow_sum) begin
            r = '{8'h00, 6'd0, shadow_total, spd_pkg::ST_CKSUM, 1'b1};
            frame_results_due.push_back(r);
        end else begin
            for (int k = 0; k < shadow_total; k++) begin
                r = '{shadow_buf[k], 6'(k), shadow_total, spd_pkg::ST_GOOD,
                      (k + 1 == shadow_total)};
                frame_results_due.push_back(r);
            end
        end
        drop_shadow_frame();
    endtask

    // ------------------------------------------------------------------
    // Byte sender: predicts, idles at random, then holds the item until taken
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input t_frame_result res);
        int prior_count;
        prior_count = frame_results_due.size();
        deframe_byte(b);
        if (typed) begin
            while (frame_results_due.size() > prior_count)
                void'(frame_results_due.pop_back());
            frame_results_due.push_back(res);
        end
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // Drain all expected items, then let the block finish any silent byte.
    task automatic settle();
        push <= 1'b0;
        while (frame_results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_header(input logic [47:0] v);
        i_cfg_we      <= 1'b1;
        i_cfg_wdata   <= v;
        shadow_header  = v;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
    endtask

    // Builds one frame (or junk) of the given kind against the current header.
    task automatic send_frame(input t_frame_kind kind, inout int counted);
        logic [7:0]  bytes [$];
        logic [15:0] len;
        logic [15:0] sum;
        logic [7:0]  pb;
        int          n;
        case (kind)
            FR_NOISE: begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom), 1'b0, NO_RES);
                // break a header the noise happened to start
                if (shadow_count != 0 && shadow_count < spd_pkg::HDR_LEN)
                    send_byte(header_byte(shadow_count) ^ 8'($urandom_range(1, 255)),
                              1'b0, NO_RES);
            end
            FR_BAD_HEADER: begin
                n = $urandom_range(0, spd_pkg::HDR_LEN - 1);
                for (int k = 0; k < n; k++) bytes.push_back(header_byte(k));
                bytes.push_back(header_byte(n) ^ 8'($urandom_range(1, 255)));
            end
            FR_BAD_LENGTH: begin
                case ($urandom_range(0, 2))
                    0:       len = 16'($urandom_range(0, 1));
                    1:       len = 16'($urandom_range(FRAME_CAP - spd_pkg::FRAME_OVERHEAD + 1,
                                                      255));
                    default: len = 16'($urandom_range(256, 65535));
                endcase
                for (int k = 0; k < spd_pkg::HDR_LEN; k++) bytes.push_back(header_byte(k));
                bytes.push_back(len[15:8]);
                bytes.push_back(len[7:0]);
            end
            default: begin
                len = (kind == FR_GOOD_MAX) ? 16'(FRAME_CAP - spd_pkg::FRAME_OVERHEAD)
                                            : 16'($urandom_range(2, 10));
                for (int k = 0; k < spd_pkg::HDR_LEN; k++) bytes.push_back(header_byte(k));
                bytes.push_back(len[15:8]);
                bytes.push_back(len[7:0]);
                sum = 16'(len[15:8]) + 16'(len[7:0]);
                for (int k = 0; k < len - 1; k++) begin
                    pb = 8'($urandom);
                    bytes.push_back(pb);
                    sum = sum + 16'(pb);
                end
                if (kind == FR_BAD_CKSUM) sum = sum ^ 16'($urandom_range(1, 65535));
                bytes.push_back(sum[15:8]);
                bytes.push_back(sum[7:0]);
            end
        endcase
        foreach (bytes[i]) send_byte(bytes[i], 1'b0, NO_RES);
        counted += bytes.size();
    endtask

    // ------------------------------------------------------------------
    // Result side: check each popped item, then pick pop for the next cycle
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_frame_result got;
        t_frame_result want;
        if (i_rst_n && pop && !empty) begin
            got = '{o_out_byte, o_byte_index, o_frame_length, o_status, o_last_of_run};
            if (frame_results_due.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected item: byte %h idx %0d len %0d st %0d last %0b",
                             got.data, got.idx, got.len, got.st, got.last);
                mismatches++;
            end else begin
                want = frame_results_due.pop_front();
                if (got.data != want.data || got.idx != want.idx || got.len != want.len ||
                    got.st != want.st || got.last != want.last) begin
                    if (mismatches < 10)
                        $display("mismatch: exp %h/%0d/%0d/%0d/%0b got %h/%0d/%0d/%0d/%0b",
                                 want.data, want.idx, want.len, want.st, want.last,
                                 got.data, got.idx, got.len, got.st, got.last);
                    mismatches++;
                end
            end
        end
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Directed rows, all under the reset header of zeros
    // ------------------------------------------------------------------
    t_directed_row directed_rows [0:22] = '{
        // header breaks on its fourth byte; the all-ones byte is not retried
        '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        // length 0xFFFF, far beyond the buffer
        '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'hFF, 1'b0, NO_RES},
        '{8'hFF, 1'b1, '{8'h00, 6'd0, 7'd8, spd_pkg::ST_LEN, 1'b1}},
        // smallest frame, sum 0x0101 against checksum 0x0100
        '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES}, '{8'h00, 1'b0, NO_RES},
        '{8'h00, 1'b0, NO_RES}, '{8'h02, 1'b0, NO_RES}, '{8'hFF, 1'b0, NO_RES},
        '{8'h01, 1'b0, NO_RES},
        '{8'h00, 1'b1, '{8'h00, 6'd0, 7'd11, spd_pkg::ST_CKSUM, 1'b1}}
    };

    initial begin : watchdog
        repeat (RUN_LIMIT) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        logic [47:0] phase_headers [0:5];
        t_frame_kind kind;
        int          counted;

        phase_headers[0] = 48'hFFFF_FFFF_FFFF;
        phase_headers[1] = {16'($urandom), 32'($urandom)};
        phase_headers[2] = 48'h0000_0000_0000;
        phase_headers[3] = {16'($urandom), 32'($urandom)};
        phase_headers[4] = {16'($urandom), 32'($urandom)};
        phase_headers[5] = {16'($urandom), 32'($urandom)};

        sender_idle_pct = 27;
        recv_idle_pct   = 60;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].res);

        for (int phase = 0; phase < 6; phase++) begin
            settle();
            write_header(phase_headers[phase]);
            case (phase / 2)
                0: begin sender_idle_pct = 27; recv_idle_pct = 60; end
                1: begin sender_idle_pct = 60; recv_idle_pct = 27; end
                default: begin sender_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                case ($urandom_range(0, 9))
                    0:       kind = FR_NOISE;
                    1:       kind = FR_BAD_HEADER;
                    2:       kind = FR_BAD_LENGTH;
                    3:       kind = FR_BAD_CKSUM;
                    default: kind = FR_GOOD;
                endcase
                // one frame of the largest size in the run
                if (phase == 0 && counted == 0) kind = FR_GOOD_MAX;
                send_frame(kind, counted);
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && frame_results_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/spd_pkg.sv
sv/spd_cmd_fifo.sv
sv/spd_front.sv
sv/spd_back.sv
sv/sensor_packet_deframer.sv
sim/sensor_packet_deframer_tb.sv
